### design/zpfc_pkg.sv
// ----------------------------------------------------------------------------
// Zero-padded FIR convolution package
// Shared widths, defaults and register indexes for the convolution core.
// ----------------------------------------------------------------------------
package zpfc_pkg;

  // Defaults for the top-level parameters
  localparam int MASK_TAPS_DEF   = 7;
  localparam int SAMPLE_BITS_DEF = 16;

  // Coefficient bank: always seven registers, only the first MASK_TAPS are used
  localparam int MAX_TAPS       = 7;
  localparam int COEF_BITS      = 16;

  // Result word width
  localparam int RESULT_BITS    = 34;

  // Configuration write channel
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COEF_BITS;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_COEF_0 = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_COEF_6 = CFG_INDEX_BITS'(MAX_TAPS - 1);

endpackage

### design/zpfc_mac.sv
// ----------------------------------------------------------------------------
// Zero-padded FIR convolution multiply-accumulate pipeline
// Registers one product per tap, then registers the wrapped sum of products.
// ----------------------------------------------------------------------------
module zpfc_mac #(
  parameter int MASK_TAPS   = zpfc_pkg::MASK_TAPS_DEF,
  parameter int SAMPLE_BITS = zpfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_last,
  input  logic signed [SAMPLE_BITS-1:0]          window [MASK_TAPS],
  input  logic signed [zpfc_pkg::COEF_BITS-1:0]  coef   [zpfc_pkg::MAX_TAPS],
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [zpfc_pkg::RESULT_BITS-1:0]       out_result,
  output logic                                   out_last
);
  import zpfc_pkg::*;

  localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
  localparam int GROW_W  = PROD_W + $clog2(MASK_TAPS);
  localparam int ACC_W   = (GROW_W > RESULT_BITS) ? GROW_W : RESULT_BITS;

  logic signed [PROD_W-1:0] prod [MASK_TAPS];
  logic                     p_valid;
  logic                     p_last;
  logic                     p_adv;
  logic                     p_load;
  logic signed [ACC_W-1:0]  acc;

  // Stage handshake: each stage moves when the next one is free
  assign p_adv    = p_valid && (!out_valid || out_ready);
  assign in_ready = !p_valid || p_adv;
  assign p_load   = in_valid && in_ready;

  // Hold valid flags for both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        p_valid <= in_valid;
      end
      if (!out_valid || out_ready) begin
        out_valid <= p_valid;
      end
    end
  end

  // Register one product per tap
  always_ff @(posedge clk) begin
    if (p_load) begin
      for (int k = 0; k < MASK_TAPS; k++) begin
        prod[k] <= window[k] * coef[k];
      end
      p_last <= in_last;
    end
  end

  // Sum the products, wrapping to the result width
  always_comb begin
    acc = '0;
    for (int k = 0; k < MASK_TAPS; k++) begin
      acc = acc + ACC_W'(prod[k]);
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_result <= acc[RESULT_BITS-1:0];
      out_last   <= p_last;
    end
  end

endmodule

### design/zero_padded_fir_convolution_core.sv
// A result word passes through the window register, the product registers and the result register.
// Throughput: one sample per cycle while m_tready does not stall the pipeline; after a sample with tlast set,
// the window shift register takes MASK_TAPS/2 zero-padding shifts before the next sample.
// Reset (rst, synchronous): clears the window, lead count, flush counter, pipeline valids
// and all coefficients to zero.
// ----------------------------------------------------------------------------
// Zero-padded FIR convolution core
// Streaming centred 1-D convolution with zero padding at both ends of a sequence.
// ----------------------------------------------------------------------------
module zero_padded_fir_convolution_core #(
  parameter int MASK_TAPS   = zpfc_pkg::MASK_TAPS_DEF,
  parameter int SAMPLE_BITS = zpfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [zpfc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [zpfc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  // Sample stream in
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,   // sample, zero pad
  input  logic                                    s_tlast,   // final sample of sequence
  // Result stream out
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((zpfc_pkg::RESULT_BITS+7)/8)*8-1:0] m_tdata, // conv_result, zero pad
  output logic                                    m_tlast    // final result of sequence
);
  import zpfc_pkg::*;

  localparam int HALF   = MASK_TAPS / 2;
  localparam int CNT_W  = $clog2(HALF + 1);
  localparam int MDATA_W = ((RESULT_BITS + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic signed [COEF_BITS-1:0]   coef [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] window [MASK_TAPS];
  logic signed [SAMPLE_BITS-1:0] window_next [MASK_TAPS];
  logic signed [SAMPLE_BITS-1:0] base [MASK_TAPS];
  logic [CNT_W-1:0]              lead_count, lead_count_next;
  logic [CNT_W-1:0]              flush_left, flush_left_next;
  logic                          emit_pending, emit_pending_next;
  logic                          win_last, win_last_next;

  logic                          mac_ready;
  logic                          clear_now;
  logic                          s1_free;
  logic                          take;
  logic                          flush_step;
  logic signed [SAMPLE_BITS-1:0] shift_val;
  logic [RESULT_BITS-1:0]        mac_result;

  // Coefficient registers; writes beyond the bank are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index <= CFG_IDX_COEF_6)) begin
      coef[cfg_index] <= $signed(cfg_data);
    end
  end

  // Window stage handshake
  always_comb begin
    s1_free    = !emit_pending || mac_ready;
    clear_now  = emit_pending && win_last && mac_ready;
    s_tready   = s1_free && (flush_left == '0);
    take       = s_tvalid && s_tready;
    flush_step = s1_free && (flush_left != '0);
    shift_val  = take ? $signed(s_tdata[SAMPLE_BITS-1:0]) : '0;
  end

  // Advance the window: a new sample, or a zero while flushing
  always_comb begin
    for (int k = 0; k < MASK_TAPS; k++) begin
      base[k] = clear_now ? '0 : window[k];
    end
    for (int k = 0; k < MASK_TAPS; k++) begin
      window_next[k] = base[k];
    end
    if (take || flush_step) begin
      for (int k = 0; k < MASK_TAPS - 1; k++) begin
        window_next[k] = base[k + 1];
      end
      window_next[MASK_TAPS-1] = shift_val;
    end
  end

  // Decide whether this shift yields a result and track the lead-in and flush
  always_comb begin
    lead_count_next   = lead_count;
    flush_left_next   = flush_left;
    emit_pending_next = emit_pending && !mac_ready;
    win_last_next     = win_last;
    if (take) begin
      emit_pending_next = (lead_count >= HALF_CNT);
      win_last_next     = 1'b0;
      if (lead_count < HALF_CNT) begin
        lead_count_next = lead_count + ONE_CNT;
      end
      if (s_tlast) begin
        flush_left_next = HALF_CNT;
      end
    end else if (flush_step) begin
      // Emit once the padded output lands inside the sequence
      emit_pending_next = (lead_count >= flush_left);
      win_last_next     = (flush_left == ONE_CNT);
      flush_left_next   = flush_left - ONE_CNT;
      if (flush_left == ONE_CNT) begin
        lead_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MASK_TAPS; k++) begin
        window[k] <= '0;
      end
      lead_count   <= '0;
      flush_left   <= '0;
      emit_pending <= 1'b0;
      win_last     <= 1'b0;
    end else begin
      window       <= window_next;
      lead_count   <= lead_count_next;
      flush_left   <= flush_left_next;
      emit_pending <= emit_pending_next;
      win_last     <= win_last_next;
    end
  end

  // Multiply-accumulate pipeline and result register
  zpfc_mac #(
    .MASK_TAPS   (MASK_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (emit_pending),
    .in_ready   (mac_ready),
    .in_last    (win_last),
    .window     (window),
    .coef       (coef),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (mac_result),
    .out_last   (m_tlast)
  );

  assign m_tdata = MDATA_W'(mac_result);

`ifndef SYNTH
  // No new word is taken while zero padding is being shifted in
  a_no_take_in_flush: assert property (@(posedge clk) disable iff (rst)
    (flush_left != '0) |-> !s_tready)
    else $error("sample word accepted during flush");

  // A pending final result only exists once the flush has finished
  a_last_after_flush: assert property (@(posedge clk) disable iff (rst)
    (emit_pending && win_last) |-> (flush_left == '0))
    else $error("final result pending while flush still running");

  // The lead-in count saturates at the half mask length
  a_lead_bound: assert property (@(posedge clk) disable iff (rst)
    lead_count <= HALF_CNT)
    else $error("lead count beyond half mask length");

  // After the final result is handed on, the window is empty unless a new word arrived
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (clear_now && !take) |=> (window[MASK_TAPS-1] == '0) && (lead_count == '0))
    else $error("window not cleared after final result");
`endif

endmodule
